[design/i2cbs_pkg.sv]
// Package for the I2C master bit sequencer: opcodes, command kinds and item types.
// It depends on nothing; every other file of the block imports it.
package i2cbs_pkg;

    // Opcodes as they arrive on the command channel.
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_STOP     = 3'd1;
    localparam logic [2:0] OP_WRITE    = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_SEND_ACK = 3'd4;
    localparam logic [2:0] OP_RECV_ACK = 3'd5;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = $clog2(BITS_PER_BYTE);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_BYTE - 1);

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Phase position inside one command or one bit slot.
    localparam logic [1:0] SUB_0 = 2'd0;
    localparam logic [1:0] SUB_1 = 2'd1;
    localparam logic [1:0] SUB_2 = 2'd2;
    localparam logic [1:0] SUB_3 = 2'd3;

    typedef enum logic [2:0] {
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ,
        CMD_SEND_ACK,
        CMD_RECV_ACK
    } t_cmd_kind;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic [7:0] line_samples;
    } t_cmd_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sample_phase;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       last_phase;
    } t_phase_item;

    // A classified command as it sits in the queue.
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic [7:0] line_samples;
    } t_queued_cmd;

endpackage

[design/i2cbs_if.sv]
// Handshake interfaces for the command channel and the phase channel.
// Depends on i2cbs_pkg for the payload types.
interface i2cbs_cmd_if;
    import i2cbs_pkg::*;
    logic      valid;
    logic      ready;
    t_cmd_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cbs_phase_if;
    import i2cbs_pkg::*;
    logic        valid;
    logic        ready;
    t_phase_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/i2c_master_bit_sequencer.sv]
// Top level of the I2C master bit sequencer: front end with command queue and
// the phase sequencing back end. Uses i2cbs_pkg, i2cbs_if, i2cbs_front, i2cbs_back.
//
// Usage: commands (start, stop, write byte, read byte, send ack, receive ack)
// enter on i_cmd; every bus phase leaves as one item on o_phase, carrying the
// SCL level, the SDA drive (1 is released) and a flag for sample phases. The
// read byte and the received acknowledge appear on the command's last phase.
// Unused opcodes are accepted and produce no phases.
// When the engine is idle, the first phase of a command passes through the queue,
// the command register and the output register. Throughput: one phase per cycle
// while the receiver takes them, so a command occupies the back end for its 3 to
// 25 phases; the sequencer loads the next queued command in the cycle of the last
// phase, so runs of commands leave without gaps. A two-entry queue lets new commands
// be accepted while a command is still being sequenced.
// When the receiver stalls, the output register holds its phase and the
// sequencer waits; the queue keeps accepting until it is full.
// Reset (synchronous, active low) empties the queue, drops the command in
// progress and returns both line levels to released high.
module i2c_master_bit_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    i2cbs_cmd_if.sink      i_cmd,
    i2cbs_phase_if.source  o_phase
);
    import i2cbs_pkg::*;

    // Classified commands between the two halves.
    logic        q_valid;
    logic        q_ready;
    t_queued_cmd q_entry;

    i2cbs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_entry (q_entry)
    );

    // The back end owns the line levels, so they persist across commands.
    i2cbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_entry (q_entry),
        .o_phase   (o_phase)
    );

endmodule

[design/i2cbs_front.sv]
// Front end of the I2C master bit sequencer: accepts commands, drops unused
// opcodes and holds classified commands in a short queue. Uses i2cbs_pkg, i2cbs_if.
module i2cbs_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    i2cbs_cmd_if.sink               i_cmd,
    output logic                    o_q_valid,
    input  logic                    i_q_ready,
    output i2cbs_pkg::t_queued_cmd  o_q_entry
);
    import i2cbs_pkg::*;

    t_queued_cmd          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]     r_count, n_count;

    logic                 legal;
    t_cmd_kind            kind;
    logic                 push;
    logic                 pop;
    t_queued_cmd          entry;

    // Decode the opcode; the two unused codes produce no phases at all.
    always_comb begin
        legal = 1'b1;
        kind  = CMD_START;
        unique case (i_cmd.data.opcode)
            OP_START:    kind = CMD_START;
            OP_STOP:     kind = CMD_STOP;
            OP_WRITE:    kind = CMD_WRITE;
            OP_READ:     kind = CMD_READ;
            OP_SEND_ACK: kind = CMD_SEND_ACK;
            OP_RECV_ACK: kind = CMD_RECV_ACK;
            default:     legal = 1'b0;
        endcase
    end

    assign entry.kind         = kind;
    assign entry.tx_byte      = i_cmd.data.tx_byte;
    assign entry.ack_to_send  = i_cmd.data.ack_to_send;
    assign entry.line_samples = i_cmd.data.line_samples;

    assign i_cmd.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push        = i_cmd.valid && i_cmd.ready && legal;
    assign o_q_valid   = (r_count != '0);
    assign pop         = o_q_valid && i_q_ready;
    assign o_q_entry   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= entry;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("command queue count beyond its depth");

    a_unused_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && !legal) |=> (r_count <= $past(r_count)))
        else $error("unused opcode entered the command queue");
`endif

endmodule

[design/i2cbs_back.sv]
// Back end of the I2C master bit sequencer: walks one queued command through its
// bus phases and holds the line levels and the output register. Uses i2cbs_pkg, i2cbs_if.
module i2cbs_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    output logic                    o_q_ready,
    input  i2cbs_pkg::t_queued_cmd  i_q_entry,
    i2cbs_phase_if.source           o_phase
);
    import i2cbs_pkg::*;

    logic             r_busy, n_busy;
    t_queued_cmd      r_cmd;
    logic [1:0]       r_sub, n_sub;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_scl, r_sda;
    logic             r_out_valid, n_out_valid;
    t_phase_item      r_out;

    t_phase_item      ph;
    logic             advance;
    logic             load;

    assign advance = r_busy && (!r_out_valid || o_phase.ready);

    // Phase of the current command at the current position. Levels shown are
    // the ones in force after this phase; a sample phase leaves them alone.
    always_comb begin
        ph.scl_out      = r_scl;
        ph.sda_out      = r_sda;
        ph.sample_phase = 1'b0;
        ph.rx_byte      = '0;
        ph.ack_seen     = 1'b0;
        ph.last_phase   = 1'b0;
        unique case (r_cmd.kind)
            CMD_START: begin
                case (r_sub)
                    SUB_0:   ph.sda_out = 1'b1;
                    SUB_1:   ph.scl_out = 1'b1;
                    SUB_2:   ph.sda_out = 1'b0;
                    default: begin
                        ph.scl_out    = 1'b0;
                        ph.last_phase = 1'b1;
                    end
                endcase
            end
            CMD_STOP: begin
                case (r_sub)
                    SUB_0:   ph.sda_out = 1'b0;
                    SUB_1:   ph.scl_out = 1'b1;
                    default: begin
                        ph.sda_out    = 1'b1;
                        ph.last_phase = 1'b1;
                    end
                endcase
            end
            CMD_WRITE: begin
                case (r_sub)
                    SUB_0:   ph.sda_out = r_cmd.tx_byte[LAST_BIT - r_bit];
                    SUB_1:   ph.scl_out = 1'b1;
                    default: begin
                        ph.scl_out    = 1'b0;
                        ph.last_phase = (r_bit == LAST_BIT);
                    end
                endcase
            end
            CMD_READ: begin
                // The sampled levels assemble into the byte exactly as given.
                case (r_sub)
                    SUB_0:   ph.sda_out = 1'b1;
                    SUB_1:   ph.scl_out = 1'b1;
                    SUB_2:   ph.sample_phase = 1'b1;
                    default: begin
                        ph.scl_out    = 1'b0;
                        ph.last_phase = (r_bit == LAST_BIT);
                        ph.rx_byte    = (r_bit == LAST_BIT) ? r_cmd.line_samples : 8'h00;
                    end
                endcase
            end
            CMD_SEND_ACK: begin
                case (r_sub)
                    SUB_0:   ph.sda_out = r_cmd.ack_to_send;
                    SUB_1:   ph.scl_out = 1'b1;
                    default: begin
                        ph.scl_out    = 1'b0;
                        ph.last_phase = 1'b1;
                    end
                endcase
            end
            CMD_RECV_ACK: begin
                case (r_sub)
                    SUB_0:   ph.sda_out = 1'b1;
                    SUB_1:   ph.scl_out = 1'b1;
                    SUB_2:   ph.sample_phase = 1'b1;
                    default: begin
                        ph.scl_out    = 1'b0;
                        ph.last_phase = 1'b1;
                        ph.ack_seen   = r_cmd.line_samples[7];
                    end
                endcase
            end
            default: ;
        endcase
    end

    // A new command is taken as soon as the current one emits its last phase.
    assign load      = i_q_valid && o_q_ready;
    assign o_q_ready = !r_busy || (advance && ph.last_phase);

    always_comb begin
        n_busy      = r_busy;
        n_sub       = r_sub;
        n_bit       = r_bit;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_phase.ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_busy = 1'b1;
            n_sub  = SUB_0;
            n_bit  = '0;
        end else if (advance && ph.last_phase) begin
            n_busy = 1'b0;
        end else if (advance) begin
            if (r_cmd.kind == CMD_WRITE && r_sub == SUB_2) begin
                n_sub = SUB_0;
                n_bit = r_bit + 1'b1;
            end else if (r_cmd.kind == CMD_READ && r_sub == SUB_3) begin
                n_sub = SUB_1;
                n_bit = r_bit + 1'b1;
            end else begin
                n_sub = r_sub + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sub       <= SUB_0;
            r_bit       <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_sub       <= n_sub;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_scl <= ph.scl_out;
                r_sda <= ph.sda_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_q_entry;
        end
        if (advance) begin
            r_out <= ph;
        end
    end

    assign o_phase.valid = r_out_valid;
    assign o_phase.data  = r_out;

`ifndef ASSERT_OFF
    a_sample_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sample_phase) |-> r_out.scl_out)
        else $error("SDA sampled while SCL is low");

    a_report_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_phase) |-> (r_out.rx_byte == 8'h00 && !r_out.ack_seen))
        else $error("read result shown before the last phase");

    a_busy_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !ph.last_phase) |=> r_busy)
        else $error("command dropped before its last phase");

    a_bit_only_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !(r_cmd.kind == CMD_WRITE || r_cmd.kind == CMD_READ)) |-> (r_bit == '0))
        else $error("bit counter moved outside a byte command");
`endif

endmodule

[verif/tb.sv]
// Self-checking testbench for the I2C master bit sequencer: drives commands, predicts every bus phase.
// Depends on i2cbs_pkg, the i2cbs_cmd_if and i2cbs_phase_if interfaces, and the design top level.
module tb;
    import i2cbs_pkg::*;

    // Opcodes that the block accepts but turns into no bus phases at all.
    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam int RANDOM_COMMANDS = 460;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 40;

    // Traffic mixes that the random part steps through, one quarter of the commands each.
    typedef enum logic [1:0] {
        MIX_STEADY,
        MIX_SENDER_IDLE,
        MIX_RECEIVER_STALL,
        MIX_BOTH_IDLE
    } t_traffic_mix;

    typedef struct packed {
        t_cmd_item    cmd;
        t_traffic_mix mix;
    } t_pending_cmd;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Local copies of the driven channel signals, so they are known from time zero.
    logic      cmd_valid   = 1'b0;
    t_cmd_item cmd_data    = '0;
    logic      phase_ready = 1'b0;

    i2cbs_cmd_if   cmd_if ();
    i2cbs_phase_if phase_if ();

    assign cmd_if.valid   = cmd_valid;
    assign cmd_if.data    = cmd_data;
    assign phase_if.ready = phase_ready;

    i2c_master_bit_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_phase (phase_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pending_cmd  pending_cmds[$];
    t_phase_item   expected_phases[$];
    t_traffic_mix  active_mix = MIX_STEADY;
    t_traffic_mix  fill_mix   = MIX_STEADY;
    int            random_cmds_queued = 0;
    bit            filling_random     = 1'b0;
    int            failures           = 0;
    int            phases_checked     = 0;
    int            cmds_by_opcode[8];

    // Predicted bus line levels; both lines are released after reset.
    logic bus_scl = 1'b1;
    logic bus_sda = 1'b1;

    function automatic int sender_idle_pct(input t_traffic_mix mix);
        case (mix)
            MIX_SENDER_IDLE: return 71;
            MIX_BOTH_IDLE:   return 14;
            default:         return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input t_traffic_mix mix);
        case (mix)
            MIX_RECEIVER_STALL: return 71;
            MIX_BOTH_IDLE:      return 14;
            default:            return 0;
        endcase
    endfunction

    // Record one bus phase at the line levels now in force.
    task automatic push_phase(input logic samp, input logic [7:0] rx, input logic ack,
                              input logic last);
        t_phase_item ph;
        ph.scl_out      = bus_scl;
        ph.sda_out      = bus_sda;
        ph.sample_phase = samp;
        ph.rx_byte      = rx;
        ph.ack_seen     = ack;
        ph.last_phase   = last;
        expected_phases.push_back(ph);
    endtask

    task automatic drive_sda_phase(input logic level, input logic last);
        bus_sda = level;
        push_phase(1'b0, 8'h00, 1'b0, last);
    endtask

    task automatic drive_scl_phase(input logic level, input logic last);
        bus_scl = level;
        push_phase(1'b0, 8'h00, 1'b0, last);
    endtask

    // Work out the full run of bus phases that one accepted command causes.
    task automatic predict_bus_phases(input t_cmd_item cmd);
        logic [7:0] assembled;
        int         i;
        assembled = 8'h00;
        case (cmd.opcode)
            OP_START: begin
                drive_sda_phase(1'b1, 1'b0);
                drive_scl_phase(1'b1, 1'b0);
                drive_sda_phase(1'b0, 1'b0);
                drive_scl_phase(1'b0, 1'b1);
            end
            OP_STOP: begin
                drive_sda_phase(1'b0, 1'b0);
                drive_scl_phase(1'b1, 1'b0);
                drive_sda_phase(1'b1, 1'b1);
            end
            OP_WRITE: begin
                for (i = 0; i < BITS_PER_BYTE; i++) begin
                    drive_sda_phase(cmd.tx_byte[BITS_PER_BYTE - 1 - i], 1'b0);
                    drive_scl_phase(1'b1, 1'b0);
                    drive_scl_phase(1'b0, i == BITS_PER_BYTE - 1);
                end
            end
            OP_READ: begin
                drive_sda_phase(1'b1, 1'b0);
                for (i = 0; i < BITS_PER_BYTE; i++) begin
                    drive_scl_phase(1'b1, 1'b0);
                    assembled[BITS_PER_BYTE - 1 - i] = cmd.line_samples[BITS_PER_BYTE - 1 - i];
                    // The sample phase leaves both lines where they are.
                    push_phase(1'b1, 8'h00, 1'b0, 1'b0);
                    bus_scl = 1'b0;
                    if (i == BITS_PER_BYTE - 1) begin
                        push_phase(1'b0, assembled, 1'b0, 1'b1);
                    end else begin
                        push_phase(1'b0, 8'h00, 1'b0, 1'b0);
                    end
                end
            end
            OP_SEND_ACK: begin
                drive_sda_phase(cmd.ack_to_send, 1'b0);
                drive_scl_phase(1'b1, 1'b0);
                drive_scl_phase(1'b0, 1'b1);
            end
            OP_RECV_ACK: begin
                drive_sda_phase(1'b1, 1'b0);
                drive_scl_phase(1'b1, 1'b0);
                push_phase(1'b1, 8'h00, 1'b0, 1'b0);
                bus_scl = 1'b0;
                push_phase(1'b0, 8'h00, cmd.line_samples[7], 1'b1);
            end
            default: begin
                // Unused opcodes leave the bus untouched and produce nothing.
            end
        endcase
    endtask

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    function automatic string phase_text(input t_phase_item ph);
        return $sformatf("scl=%0b sda=%0b sample=%0b rx=%02h ack=%0b last=%0b",
                         ph.scl_out, ph.sda_out, ph.sample_phase, ph.rx_byte,
                         ph.ack_seen, ph.last_phase);
    endfunction

    // Command driver: presents queued commands, idling at random according to the mix.
    always @(posedge i_clk) begin : cmd_driver
        t_pending_cmd next_cmd;
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_valid && cmd_if.ready) begin
                cmds_by_opcode[cmd_data.opcode]++;
                predict_bus_phases(cmd_data);
            end
            if (!cmd_valid || cmd_if.ready) begin
                if (pending_cmds.size() > 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct(pending_cmds[0].mix)) begin
                    next_cmd   = pending_cmds.pop_front();
                    cmd_data   <= next_cmd.cmd;
                    cmd_valid  <= 1'b1;
                    active_mix <= next_cmd.mix;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Phase monitor: checks every accepted phase against the oldest prediction.
    always @(posedge i_clk) begin : phase_monitor
        t_phase_item want;
        t_phase_item got;
        if (!i_rst_n) begin
            phase_ready <= 1'b0;
        end else begin
            if (phase_if.valid && phase_ready) begin
                got = phase_if.data;
                phases_checked++;
                if (expected_phases.size() == 0) begin
                    note_failure({"unexpected phase: ", phase_text(got)});
                end else begin
                    want = expected_phases.pop_front();
                    if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                        got.sample_phase !== want.sample_phase ||
                        got.rx_byte !== want.rx_byte || got.ack_seen !== want.ack_seen ||
                        got.last_phase !== want.last_phase) begin
                        note_failure({"phase differs: expected ", phase_text(want),
                                      " got ", phase_text(got)});
                    end
                end
            end
            phase_ready <= ($urandom_range(0, 99) >= receiver_stall_pct(active_mix));
        end
    end

    task automatic queue_command(input logic [2:0] op, input logic [7:0] tx,
                                 input logic ackbit, input logic [7:0] samples);
        t_pending_cmd p;
        p.cmd.opcode       = op;
        p.cmd.tx_byte      = tx;
        p.cmd.ack_to_send  = ackbit;
        p.cmd.line_samples = samples;
        p.mix              = fill_mix;
        pending_cmds.push_back(p);
        if (filling_random && op <= OP_RECV_ACK) begin
            random_cmds_queued++;
        end
    endtask

    // Queue one command of the given opcode with random remaining fields.
    task automatic queue_random_fields(input logic [2:0] op);
        queue_command(op, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    // A well-formed transfer: start, address byte with acknowledge, data bytes, stop.
    task automatic queue_transfer();
        int n_bytes;
        n_bytes = $urandom_range(0, 4);
        queue_random_fields(OP_START);
        queue_random_fields(OP_WRITE);
        queue_random_fields(OP_RECV_ACK);
        repeat (n_bytes) begin
            if ($urandom_range(0, 1) == 1) begin
                queue_random_fields(OP_WRITE);
                queue_random_fields(OP_RECV_ACK);
            end else begin
                queue_random_fields(OP_READ);
                queue_random_fields(OP_SEND_ACK);
            end
        end
        queue_random_fields(OP_STOP);
    endtask

    initial begin : stimulus
        int mix_index;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: field extremes, every opcode, both unused opcodes,
        // an acknowledge read at both levels and a repeated start.
        queue_command(OP_START, 8'h00, 1'b0, 8'h00);
        queue_command(OP_WRITE, 8'h00, 1'b1, 8'hFF);
        queue_command(OP_WRITE, 8'hFF, 1'b0, 8'h00);
        queue_command(OP_WRITE, 8'hA5, 1'b1, 8'h5A);
        queue_command(OP_RECV_ACK, 8'hFF, 1'b1, 8'h00);
        queue_command(OP_RECV_ACK, 8'h00, 1'b0, 8'h80);
        queue_command(OP_RECV_ACK, 8'h00, 1'b0, 8'h7F);
        queue_command(OP_READ, 8'hFF, 1'b1, 8'h00);
        queue_command(OP_READ, 8'h00, 1'b0, 8'hFF);
        queue_command(OP_READ, 8'h3C, 1'b0, 8'h5A);
        queue_command(OP_SEND_ACK, 8'h00, 1'b0, 8'hFF);
        queue_command(OP_SEND_ACK, 8'hFF, 1'b1, 8'h00);
        queue_command(OP_STOP, 8'h00, 1'b0, 8'h00);
        queue_command(OP_UNUSED_LO, 8'hFF, 1'b1, 8'hFF);
        queue_command(OP_UNUSED_HI, 8'h00, 1'b0, 8'h00);
        queue_command(OP_START, 8'hFF, 1'b1, 8'hFF);
        queue_command(OP_START, 8'h00, 1'b0, 8'h00);
        queue_command(OP_READ, 8'h00, 1'b1, 8'h81);
        queue_command(OP_STOP, 8'hFF, 1'b1, 8'hFF);
        queue_command(OP_STOP, 8'h00, 1'b0, 8'h00);

        // Random part: mostly well-formed transfers, the rest loose commands of
        // any opcode, which also leave transfers broken off midway.
        filling_random = 1'b1;
        while (random_cmds_queued < RANDOM_COMMANDS) begin
            mix_index = (random_cmds_queued * 4) / RANDOM_COMMANDS;
            fill_mix  = t_traffic_mix'(mix_index > 3 ? 3 : mix_index);
            if ($urandom_range(0, 9) < 8) begin
                queue_transfer();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    queue_random_fields(3'($urandom_range(0, 7)));
                end
            end
        end

        while (pending_cmds.size() > 0 || cmd_valid) @(posedge i_clk);
        while (expected_phases.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_phases.size() > 0) begin
            note_failure($sformatf("%0d predicted phases never arrived",
                                   expected_phases.size()));
        end
        $display("Commands run: start %0d, stop %0d, write %0d, read %0d, ack out %0d, ack in %0d",
                 cmds_by_opcode[OP_START], cmds_by_opcode[OP_STOP], cmds_by_opcode[OP_WRITE],
                 cmds_by_opcode[OP_READ], cmds_by_opcode[OP_SEND_ACK],
                 cmds_by_opcode[OP_RECV_ACK]);
        $display("Unused opcodes %0d; %0d bus phases checked over four traffic mixes, %0d failures",
                 cmds_by_opcode[OP_UNUSED_LO] + cmds_by_opcode[OP_UNUSED_HI],
                 phases_checked, failures);
        if (failures == 0) begin
            $display("i2c_master_bit_sequencer: match");
        end else begin
            $display("i2c_master_bit_sequencer: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #5000000;
        $display("Run did not finish in time");
        $display("i2c_master_bit_sequencer: mismatch");
        $finish;
    end

endmodule

[sim.f]
design/i2cbs_pkg.sv
design/i2cbs_if.sv
design/i2cbs_front.sv
design/i2cbs_back.sv
design/i2c_master_bit_sequencer.sv
verif/tb.sv
